// ===== rtl/tsr_pkg.sv =====
// Shared types, constants and arithmetic helpers for the three-shear address map.
`timescale 1ns / 1ps

package tsr_pkg;

	localparam int unsigned SUB_W        = 11;
	localparam int unsigned COEF_W       = 18;
	localparam int unsigned COORD_W      = 18;
	localparam int unsigned PROD_W       = COEF_W + COORD_W;
	localparam int unsigned FRAC_W       = 16;
	localparam int unsigned INDEX_W      = 22;
	localparam int unsigned CFG_IDX_W    = 3;
	localparam int unsigned CFG_DATA_W   = 18;

	localparam logic [SUB_W-1:0] MIN_SUB_SIZE = SUB_W'(16);
	localparam logic [SUB_W-1:0] MAX_SUB_SIZE = SUB_W'(1024);
	localparam logic [SUB_W-1:0] RST_SUB_SIZE = SUB_W'(256);

	localparam int unsigned MOD_W      = 16;
	localparam int unsigned MOD_STEPS  = 4;
	localparam int unsigned MOD_STAGES = 3;
	localparam int unsigned MOD_TOP    = MOD_STEPS * MOD_STAGES - 1;
	localparam int unsigned MOD_CMP_W  = MOD_W + SUB_W + 1;

	localparam logic [CFG_IDX_W-1:0] REG_MODE     = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_SUB_SIZE = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT_X  = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Y  = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_COEF_X   = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] REG_COEF_Y   = CFG_IDX_W'(5);

	localparam logic MODE_PUSH = 1'b0;
	localparam logic MODE_PULL = 1'b1;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic                      ok;
	} pt_t;

	// restoring remainder: MOD_STEPS trial subtractions of fld << top down to fld << (top - 3)
	function automatic logic [MOD_W-1:0] rem_steps(
		input logic [MOD_W-1:0] r_in,
		input logic [SUB_W-1:0] fld,
		input int unsigned      top
	);
		logic [MOD_CMP_W-1:0] r;
		logic [MOD_CMP_W-1:0] d;
		int unsigned          i;
		r = MOD_CMP_W'(r_in);
		for (i = 0; i < MOD_STEPS; i++) begin
			d = MOD_CMP_W'(fld) << (top - i);
			if (r >= d) begin
				r = r - d;
			end
		end
		return r[MOD_W-1:0];
	endfunction

endpackage

// ===== rtl/three_shear_rotation_address_map_top.sv =====
// Three-shear rotation address map: one pixel coordinate in, one source address out.
`timescale 1ns / 1ps

// Takes one word per clock and returns one word per clock while out_stall is low; each word
// passes through an input stage, a three-stage remainder unit that wraps the shifted field
// coordinate, a centring stage, three shears of two stages each (multiply, then round and
// add), a range stage, a second three-stage remainder unit that folds pull results into the
// field, an index multiply stage and the output register. Stalls propagate stage by stage,
// so empty stages keep filling while a result waits at the output. Every stage reads the
// live configuration, also for words in flight; write only while the pipeline is empty.

module three_shear_rotation_address_map_top
	import tsr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [SUB_W-1:0]      pos_x,
	input  logic [SUB_W-1:0]      pos_y,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [SUB_W-1:0]      out_x,
	output logic [SUB_W-1:0]      out_y,
	output logic [INDEX_W-1:0]    out_index,
	output logic                  in_range
);

	logic                     mode_q;
	logic [SUB_W-1:0]         sub_size_q;
	logic [SUB_W-1:0]         shift_x_q;
	logic [SUB_W-1:0]         shift_y_q;
	logic signed [COEF_W-1:0] coef_x_q;
	logic signed [COEF_W-1:0] coef_y_q;

	logic [SUB_W-1:0]   s_eff;
	logic [SUB_W-1:0]   f_eff;
	logic [SUB_W-2:0]   s_half;
	logic [SUB_W-2:0]   f_half;
	logic [SUB_W-1:0]   side;

	logic               v_s1, v_s2, v_s3, v_s4, v_s5;
	logic               en_s1, en_s2, en_s3, en_s4, en_s5;
	pt_t                pt_s1, pt_s2, pt_s3;
	pt_t                pt_in_d, pt_ctr_d, pt_post_d;
	logic [INDEX_W-1:0] prod_s4;
	logic [SUB_W-1:0]   rx_s4;
	logic [SUB_W-1:0]   ry_s4;
	logic               ok_s4;
	logic [SUB_W-1:0]   out_x_s5;
	logic [SUB_W-1:0]   out_y_s5;
	logic [INDEX_W-1:0] out_index_s5;
	logic               in_range_s5;

	logic               moda_in_ready, moda_out_valid;
	pt_t                moda_pt;
	logic               sh1_in_ready, sh1_out_valid, sh1_out_ready;
	pt_t                sh1_pt;
	logic               sh2_in_ready, sh2_out_valid;
	pt_t                sh2_pt;
	logic               sh3_in_ready_w;
	logic               sh3_out_valid;
	pt_t                sh3_pt;
	logic               modb_in_ready, modb_out_valid;
	pt_t                modb_pt;
	logic signed [COORD_W-1:0] tx, ty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_PUSH;
			sub_size_q <= RST_SUB_SIZE;
			shift_x_q  <= '0;
			shift_y_q  <= '0;
			coef_x_q   <= '0;
			coef_y_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MODE:     mode_q     <= cfg_data[0];
				REG_SUB_SIZE: sub_size_q <= cfg_data[SUB_W-1:0];
				REG_SHIFT_X:  shift_x_q  <= cfg_data[SUB_W-1:0];
				REG_SHIFT_Y:  shift_y_q  <= cfg_data[SUB_W-1:0];
				REG_COEF_X:   coef_x_q   <= $signed(cfg_data[COEF_W-1:0]);
				REG_COEF_Y:   coef_y_q   <= $signed(cfg_data[COEF_W-1:0]);
				default: ;
			endcase
		end
	end

	always_comb begin
		priority if (sub_size_q < MIN_SUB_SIZE) begin
			s_eff = MIN_SUB_SIZE;
		end else if (sub_size_q > MAX_SUB_SIZE) begin
			s_eff = MAX_SUB_SIZE;
		end else begin
			s_eff = sub_size_q;
		end
	end

	assign f_eff  = s_eff + (s_eff >> 1);
	assign s_half = s_eff[SUB_W-1:1];
	assign f_half = f_eff[SUB_W-1:1];
	assign side   = (mode_q == MODE_PULL) ? f_eff : s_eff;

	// handshake chain, output end first
	assign en_s5    = !v_s5 || !out_stall;
	assign en_s4    = !v_s4 || en_s5;
	assign en_s3    = !v_s3 || modb_in_ready;
	assign en_s2    = !v_s2 || sh1_in_ready;
	assign en_s1    = !v_s1 || moda_in_ready;
	assign in_stall = !en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= moda_out_valid;
			if (en_s3) v_s3 <= sh3_out_valid;
			if (en_s4) v_s4 <= modb_out_valid;
			if (en_s5) v_s5 <= v_s4;
		end
	end

	// push: shift ahead of wrap; pull: centre on the sub-image
	always_comb begin
		pt_in_d.ok = 1'b1;
		if (mode_q == MODE_PULL) begin
			pt_in_d.x = $signed(COORD_W'(pos_x) - COORD_W'(s_half));
			pt_in_d.y = $signed(COORD_W'(pos_y) - COORD_W'(s_half));
		end else begin
			pt_in_d.x = $signed(COORD_W'(pos_x) + COORD_W'(shift_x_q));
			pt_in_d.y = $signed(COORD_W'(pos_y) + COORD_W'(shift_y_q));
		end
	end

	always_comb begin
		pt_ctr_d = moda_pt;
		if (mode_q == MODE_PUSH) begin
			pt_ctr_d.x = moda_pt.x - $signed(COORD_W'(f_half));
			pt_ctr_d.y = moda_pt.y - $signed(COORD_W'(f_half));
		end
	end

	assign tx = sh3_pt.x + $signed(COORD_W'(f_half)) + $signed(COORD_W'(f_eff))
		- $signed(COORD_W'(shift_x_q));
	assign ty = sh3_pt.y + $signed(COORD_W'(f_half)) + $signed(COORD_W'(f_eff))
		- $signed(COORD_W'(shift_y_q));

	always_comb begin
		if (mode_q == MODE_PULL) begin
			pt_post_d.x  = tx;
			pt_post_d.y  = ty;
			pt_post_d.ok = !tx[COORD_W-1] && !ty[COORD_W-1];
		end else begin
			pt_post_d.x  = sh3_pt.x + $signed(COORD_W'(s_half));
			pt_post_d.y  = sh3_pt.y + $signed(COORD_W'(s_half));
			pt_post_d.ok = !pt_post_d.x[COORD_W-1] && !pt_post_d.y[COORD_W-1]
				&& (pt_post_d.x < $signed(COORD_W'(s_eff)))
				&& (pt_post_d.y < $signed(COORD_W'(s_eff)));
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) pt_s1 <= pt_in_d;
		if (en_s2) pt_s2 <= pt_ctr_d;
		if (en_s3) pt_s3 <= pt_post_d;
		if (en_s4) begin
			prod_s4 <= INDEX_W'(modb_pt.y[SUB_W-1:0]) * INDEX_W'(side);
			rx_s4   <= modb_pt.x[SUB_W-1:0];
			ry_s4   <= modb_pt.y[SUB_W-1:0];
			ok_s4   <= modb_pt.ok;
		end
		if (en_s5) begin
			out_x_s5     <= ok_s4 ? rx_s4 : '0;
			out_y_s5     <= ok_s4 ? ry_s4 : '0;
			out_index_s5 <= ok_s4 ? prod_s4 + INDEX_W'(rx_s4) : '0;
			in_range_s5  <= ok_s4;
		end
	end

	tsr_mod u_mod_wrap (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1),
		.in_ready  (moda_in_ready),
		.in_pt     (pt_s1),
		.fld       (f_eff),
		.reduce    (mode_q == MODE_PUSH),
		.out_valid (moda_out_valid),
		.out_ready (en_s2),
		.out_pt    (moda_pt)
	);

	tsr_shear u_shear_x1 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s2),
		.in_ready  (sh1_in_ready),
		.in_pt     (pt_s2),
		.coef      (coef_x_q),
		.upd_y     (1'b0),
		.out_valid (sh1_out_valid),
		.out_ready (sh1_out_ready),
		.out_pt    (sh1_pt)
	);

	assign sh1_out_ready = sh2_in_ready;

	tsr_shear u_shear_y (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sh1_out_valid),
		.in_ready  (sh2_in_ready),
		.in_pt     (sh1_pt),
		.coef      (coef_y_q),
		.upd_y     (1'b1),
		.out_valid (sh2_out_valid),
		.out_ready (sh3_in_ready_w),
		.out_pt    (sh2_pt)
	);

	tsr_shear u_shear_x2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sh2_out_valid),
		.in_ready  (sh3_in_ready_w),
		.in_pt     (sh2_pt),
		.coef      (coef_x_q),
		.upd_y     (1'b0),
		.out_valid (sh3_out_valid),
		.out_ready (en_s3),
		.out_pt    (sh3_pt)
	);

	tsr_mod u_mod_fold (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s3),
		.in_ready  (modb_in_ready),
		.in_pt     (pt_s3),
		.fld       (f_eff),
		.reduce    (mode_q == MODE_PULL),
		.out_valid (modb_out_valid),
		.out_ready (en_s4),
		.out_pt    (modb_pt)
	);

	assign out_valid = v_s5;
	assign out_x     = out_x_s5;
	assign out_y     = out_y_s5;
	assign out_index = out_index_s5;
	assign in_range  = in_range_s5;

	a_zero_when_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !in_range |-> out_x == '0 && out_y == '0 && out_index == '0)
		else $error("out-of-range word carries a non-zero address");

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> v_s1)
		else $error("accepted word missing from input stage");

	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled while output drains");

endmodule

// ===== rtl/tsr_mod.sv =====
// Three-stage pipelined remainder of both coordinates by the field side, applied when reduce is set.
`timescale 1ns / 1ps

module tsr_mod
	import tsr_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  pt_t              in_pt,
	input  logic [SUB_W-1:0] fld,
	input  logic             reduce,
	output logic             out_valid,
	input  logic             out_ready,
	output pt_t              out_pt
);

	logic             v_s1, v_s2, v_s3;
	logic             en_s1, en_s2, en_s3;
	pt_t              pt_s1, pt_s2, pt_s3;
	logic [MOD_W-1:0] rx_s1, rx_s2, rx_s3;
	logic [MOD_W-1:0] ry_s1, ry_s2, ry_s3;

	assign en_s3    = !v_s3 || out_ready;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			pt_s1 <= in_pt;
			rx_s1 <= rem_steps(in_pt.x[MOD_W-1:0], fld, MOD_TOP);
			ry_s1 <= rem_steps(in_pt.y[MOD_W-1:0], fld, MOD_TOP);
		end
		if (en_s2) begin
			pt_s2 <= pt_s1;
			rx_s2 <= rem_steps(rx_s1, fld, MOD_TOP - MOD_STEPS);
			ry_s2 <= rem_steps(ry_s1, fld, MOD_TOP - MOD_STEPS);
		end
		if (en_s3) begin
			pt_s3 <= pt_s2;
			rx_s3 <= rem_steps(rx_s2, fld, MOD_TOP - 2 * MOD_STEPS);
			ry_s3 <= rem_steps(ry_s2, fld, MOD_TOP - 2 * MOD_STEPS);
		end
	end

	always_comb begin
		out_pt = pt_s3;
		if (reduce) begin
			out_pt.x = $signed(COORD_W'(rx_s3));
			out_pt.y = $signed(COORD_W'(ry_s3));
		end
	end

	assign out_valid = v_s3;

endmodule

// ===== rtl/tsr_shear.sv =====
// One shear: multiply stage, then round half away from zero and add.
`timescale 1ns / 1ps

module tsr_shear
	import tsr_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  pt_t                      in_pt,
	input  logic signed [COEF_W-1:0] coef,
	input  logic                     upd_y,
	output logic                     out_valid,
	input  logic                     out_ready,
	output pt_t                      out_pt
);

	logic                      v_s1, v_s2;
	logic                      en_s1, en_s2;
	pt_t                       pt_s1, pt_s2;
	logic signed [PROD_W-1:0]  prod_s1;
	logic signed [PROD_W-1:0]  prod_d;
	logic signed [COORD_W-1:0] src;
	logic signed [PROD_W-1:0]  biased;
	logic signed [COORD_W-1:0] term;
	pt_t                       pt_d;

	assign en_s2    = !v_s2 || out_ready;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	assign src    = upd_y ? in_pt.x : in_pt.y;
	assign prod_d = coef * src;

	// ties away from zero: bias by one half, one less for negative products
	assign biased = prod_s1 + (prod_s1[PROD_W-1] ? PROD_W'(32767) : PROD_W'(32768));
	assign term   = $signed(biased[FRAC_W+COORD_W-1:FRAC_W]);

	always_comb begin
		pt_d = pt_s1;
		if (upd_y) begin
			pt_d.y = pt_s1.y + term;
		end else begin
			pt_d.x = pt_s1.x + term;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			pt_s1   <= in_pt;
			prod_s1 <= prod_d;
		end
		if (en_s2) begin
			pt_s2 <= pt_d;
		end
	end

	assign out_valid = v_s2;
	assign out_pt    = pt_s2;

endmodule

// ===== test/tsr_map_checker.sv =====
// Checker for the three-shear address map: follows the registers, predicts each word and compares.
`timescale 1ns / 1ps

module tsr_map_checker
	import tsr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic [SUB_W-1:0]      pos_x,
	input  logic [SUB_W-1:0]      pos_y,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic [SUB_W-1:0]      out_x,
	input  logic [SUB_W-1:0]      out_y,
	input  logic [INDEX_W-1:0]    out_index,
	input  logic                  in_range,
	output int                    errors,
	output int                    pending,
	output int                    checked
);

	typedef struct packed {
		logic [SUB_W-1:0]   x;
		logic [SUB_W-1:0]   y;
		logic [INDEX_W-1:0] index;
		logic               ok;
	} src_addr_t;

	logic                      mode_sel;
	logic [SUB_W-1:0]          sub_sz;
	logic [SUB_W-1:0]          shift_x;
	logic [SUB_W-1:0]          shift_y;
	logic signed [COEF_W-1:0]  coef_x;
	logic signed [COEF_W-1:0]  coef_y;
	src_addr_t                 addr_q[$];

	// round(k * v / 2^16), ties away from zero
	function automatic longint shear_term(input longint k, input longint v);
		longint p;
		longint r;
		p = k * v;
		r = ((p < 0) ? -p : p) + 32768;
		r = r >> FRAC_W;
		return (p < 0) ? -r : r;
	endfunction

	function automatic void shear3(inout longint x, inout longint y, input longint kx,
			input longint ky);
		x += shear_term(kx, y);
		y += shear_term(ky, x);
		x += shear_term(kx, y);
	endfunction

	function automatic src_addr_t map_addr(input logic [SUB_W-1:0] px_in,
			input logic [SUB_W-1:0] py_in);
		longint    s;
		longint    f;
		longint    x;
		longint    y;
		longint    rx;
		longint    ry;
		longint    tx;
		longint    ty;
		longint    side;
		logic      ok;
		src_addr_t a;
		s = longint'(sub_sz);
		if (s < longint'(MIN_SUB_SIZE)) s = longint'(MIN_SUB_SIZE);
		if (s > longint'(MAX_SUB_SIZE)) s = longint'(MAX_SUB_SIZE);
		f = (s * 3) / 2;
		if (mode_sel == MODE_PUSH) begin
			x = (longint'(px_in) + longint'(shift_x)) % f - f / 2;
			y = (longint'(py_in) + longint'(shift_y)) % f - f / 2;
			shear3(x, y, longint'(coef_x), longint'(coef_y));
			rx = x + s / 2;
			ry = y + s / 2;
			side = s;
			ok = (rx >= 0) && (rx < s) && (ry >= 0) && (ry < s);
		end else begin
			x = longint'(px_in) - s / 2;
			y = longint'(py_in) - s / 2;
			shear3(x, y, longint'(coef_x), longint'(coef_y));
			tx = x + f / 2 + f - longint'(shift_x);
			ty = y + f / 2 + f - longint'(shift_y);
			side = f;
			ok = (tx >= 0) && (ty >= 0);
			rx = tx % f;
			ry = ty % f;
		end
		a = '0;
		if (ok) begin
			a.x = SUB_W'(rx);
			a.y = SUB_W'(ry);
			a.index = INDEX_W'(ry * side + rx);
			a.ok = 1'b1;
		end
		return a;
	endfunction

	task automatic report(input string msg);
		if (errors < 40) begin
			$display("%0t ns: %s", $time, msg);
		end
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		src_addr_t want;
		if (!arst_n) begin
			mode_sel = MODE_PUSH;
			sub_sz = RST_SUB_SIZE;
			shift_x = '0;
			shift_y = '0;
			coef_x = '0;
			coef_y = '0;
			addr_q.delete();
			errors = 0;
			pending = 0;
			checked = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MODE: mode_sel = cfg_data[0];
					REG_SUB_SIZE: sub_sz = cfg_data[SUB_W-1:0];
					REG_SHIFT_X: shift_x = cfg_data[SUB_W-1:0];
					REG_SHIFT_Y: shift_y = cfg_data[SUB_W-1:0];
					REG_COEF_X: coef_x = cfg_data[COEF_W-1:0];
					REG_COEF_Y: coef_y = cfg_data[COEF_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (addr_q.size() == 0) begin
					report($sformatf("result word with nothing pending: x %0d y %0d",
						out_x, out_y));
				end else begin
					want = addr_q.pop_front();
					checked++;
					if (out_x !== want.x)
						report($sformatf("word %0d out_x: expected %0d, got %0d",
							checked, want.x, out_x));
					if (out_y !== want.y)
						report($sformatf("word %0d out_y: expected %0d, got %0d",
							checked, want.y, out_y));
					if (out_index !== want.index)
						report($sformatf("word %0d out_index: expected %0d, got %0d",
							checked, want.index, out_index));
					if (in_range !== want.ok)
						report($sformatf("word %0d in_range: expected %0d, got %0d",
							checked, want.ok, in_range));
				end
			end
			if (in_valid && !in_stall) begin
				addr_q.push_back(map_addr(pos_x, pos_y));
			end
			pending = addr_q.size();
		end
	end

endmodule

// ===== test/tb_three_shear_rotation_address_map_top.sv =====
// Testbench top for the three-shear address map: drives coordinates and registers, gives the verdict.
`timescale 1ns / 1ps

module tb_three_shear_rotation_address_map_top;
	import tsr_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int DRAIN_CYCLES   = 40;
	localparam int RANDOM_WORDS   = 650;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = REG_COEF_Y + 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = REG_COEF_Y + 3'd2;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [SUB_W-1:0]      pos_x = '0;
	logic [SUB_W-1:0]      pos_y = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [SUB_W-1:0]      out_x;
	logic [SUB_W-1:0]      out_y;
	logic [INDEX_W-1:0]    out_index;
	logic                  in_range;

	int errors;
	int pending;
	int checked;
	int idle_max = 0;
	int stall_max = 0;
	int stall_left = 0;
	int quiet_cycles = 0;
	int words_sent = 0;
	int phases = 0;

	three_shear_rotation_address_map_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_x     (out_x),
		.out_y     (out_y),
		.out_index (out_index),
		.in_range  (in_range)
	);

	tsr_map_checker u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_x     (out_x),
		.out_y     (out_y),
		.out_index (out_index),
		.in_range  (in_range),
		.errors    (errors),
		.pending   (pending),
		.checked   (checked)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// hold the result side off for a drawn number of cycles after each word taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && !out_stall) stall_left = $urandom_range(0, stall_max);
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("three_shear_rotation_address_map_top test failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_word(input logic [SUB_W-1:0] x, input logic [SUB_W-1:0] y);
		int gap;
		bit taken;
		gap = $urandom_range(0, idle_max);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		pos_x <= x;
		pos_y <= y;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end
		words_sent++;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (2) @(posedge clk);
	endtask

	task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic load_config(input logic [CFG_DATA_W-1:0] mode_d, input logic [CFG_DATA_W-1:0] sub_d,
			input logic [CFG_DATA_W-1:0] shx_d, input logic [CFG_DATA_W-1:0] shy_d,
			input logic [CFG_DATA_W-1:0] kx_d, input logic [CFG_DATA_W-1:0] ky_d, input bit spare);
		cfg_put(REG_MODE, mode_d);
		cfg_put(REG_SUB_SIZE, sub_d);
		cfg_put(REG_SHIFT_X, shx_d);
		cfg_put(REG_SHIFT_Y, shy_d);
		cfg_put(REG_COEF_X, kx_d);
		cfg_put(REG_COEF_Y, ky_d);
		if (spare) begin
			cfg_put(REG_SPARE_LO, CFG_DATA_W'($urandom));
			cfg_put(REG_SPARE_HI, CFG_DATA_W'($urandom));
		end
		cfg_we <= 1'b0;
		phases++;
	endtask

	function automatic logic [CFG_DATA_W-1:0] pick_coef();
		case ($urandom_range(0, 5))
			0: return CFG_DATA_W'($urandom_range(0, 2 ** COEF_W - 1));
			1: return $urandom_range(0, 1) ? CFG_DATA_W'(18'h20000) : CFG_DATA_W'(18'h1FFFF);
			default: return CFG_DATA_W'(int'($urandom_range(0, 131072)) - 65536);
		endcase
	endfunction

	function automatic int pick_idle();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 3;
			default: return 11;
		endcase
	endfunction

	initial begin
		logic                             mode_v;
		logic [SUB_W-1:0]                 sub_v;
		logic [SUB_W-1:0]                 shx_v;
		logic [SUB_W-1:0]                 shy_v;
		logic [CFG_DATA_W-SUB_W-1:0]      junk_hi;
		int                               s_eff;
		int                               f_side;
		int                               lim;
		int                               n_words;
		int                               random_sent;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// reset values: push, side 256, no shift, no shear
		send_word(11'd0, 11'd0);
		send_word(11'd2047, 11'd2047);
		send_word(11'd1535, 11'd0);
		send_word(11'd128, 11'd383);
		settle();

		idle_max = 3;
		stall_max = 3;
		load_config(CFG_DATA_W'(MODE_PUSH), CFG_DATA_W'(16), CFG_DATA_W'(23), CFG_DATA_W'(2047),
			CFG_DATA_W'(32768), CFG_DATA_W'(-32768), 1'b0);
		send_word(11'd0, 11'd0);
		send_word(11'd2047, 11'd2047);
		send_word(11'd13, 11'd11);
		send_word(11'd12, 11'd12);
		send_word(11'd3, 11'd20);
		settle();

		idle_max = 0;
		stall_max = 11;
		load_config(CFG_DATA_W'(MODE_PULL), CFG_DATA_W'(1024), CFG_DATA_W'(0), CFG_DATA_W'(0),
			CFG_DATA_W'(18'h1FFFF), CFG_DATA_W'(18'h20000), 1'b0);
		send_word(11'd0, 11'd0);
		send_word(11'd1023, 11'd1023);
		send_word(11'd2047, 11'd0);
		send_word(11'd0, 11'd2047);
		send_word(11'd512, 11'd512);
		settle();

		idle_max = 11;
		stall_max = 0;
		load_config(CFG_DATA_W'(18'h3FFFF), CFG_DATA_W'(0), CFG_DATA_W'(1535), CFG_DATA_W'(2047),
			CFG_DATA_W'(18'h3FFFF), CFG_DATA_W'(1), 1'b1);
		send_word(11'd0, 11'd0);
		send_word(11'd15, 11'd15);
		send_word(11'd2047, 11'd2047);
		send_word(11'd8, 11'd8);
		settle();

		load_config(CFG_DATA_W'(18'h3FFFE), CFG_DATA_W'(2047), CFG_DATA_W'(1535), CFG_DATA_W'(0),
			CFG_DATA_W'(-32768), CFG_DATA_W'(32768), 1'b0);
		send_word(11'd0, 11'd0);
		send_word(11'd1535, 11'd1535);
		send_word(11'd768, 11'd768);
		settle();

		idle_max = 0;
		load_config(CFG_DATA_W'(MODE_PUSH), CFG_DATA_W'(100), CFG_DATA_W'(0), CFG_DATA_W'(0),
			CFG_DATA_W'(0), CFG_DATA_W'(65536), 1'b0);
		send_word(11'd50, 11'd50);
		send_word(11'd149, 11'd149);
		send_word(11'd0, 11'd2047);
		settle();

		random_sent = 0;
		while (random_sent < RANDOM_WORDS) begin
			mode_v = $urandom_range(0, 1);
			sub_v = ($urandom_range(0, 7) == 0) ? SUB_W'($urandom_range(0, 2047))
				: SUB_W'(16 << $urandom_range(0, 6));
			s_eff = (sub_v < MIN_SUB_SIZE) ? int'(MIN_SUB_SIZE)
				: (sub_v > MAX_SUB_SIZE) ? int'(MAX_SUB_SIZE) : int'(sub_v);
			f_side = (s_eff * 3) / 2;
			shx_v = ($urandom_range(0, 3) == 0) ? SUB_W'($urandom_range(0, 2047))
				: SUB_W'($urandom_range(0, f_side - 1));
			shy_v = ($urandom_range(0, 3) == 0) ? SUB_W'($urandom_range(0, 2047))
				: SUB_W'($urandom_range(0, f_side - 1));
			junk_hi = ($urandom_range(0, 3) == 0) ? (CFG_DATA_W - SUB_W)'($urandom) : '0;
			idle_max = pick_idle();
			stall_max = pick_idle();
			load_config({junk_hi, SUB_W'(mode_v)}, {junk_hi, sub_v}, {junk_hi, shx_v},
				{junk_hi, shy_v}, pick_coef(), pick_coef(), $urandom_range(0, 7) == 0);
			lim = (mode_v == MODE_PUSH) ? f_side - 1 : s_eff - 1;
			n_words = $urandom_range(10, 60);
			repeat (n_words) begin
				send_word(
					($urandom_range(0, 7) == 0) ? SUB_W'($urandom_range(0, 2047))
						: SUB_W'($urandom_range(0, lim)),
					($urandom_range(0, 7) == 0) ? SUB_W'($urandom_range(0, 2047))
						: SUB_W'($urandom_range(0, lim)));
				random_sent++;
			end
			settle();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d coordinate words mapped under %0d register settings, push and pull,",
			words_sent, phases);
		$display("%0d result words compared field by field", checked);
		if (errors == 0) begin
			$display("three_shear_rotation_address_map_top test passed");
		end else begin
			$display("three_shear_rotation_address_map_top test failed");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/tsr_pkg.sv
rtl/tsr_mod.sv
rtl/tsr_shear.sv
rtl/three_shear_rotation_address_map_top.sv
test/tsr_map_checker.sv
test/tb_three_shear_rotation_address_map_top.sv
